FILE: design/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants for the UTF-8 stream decoder and validator:
// channel payloads, decoder state and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

  localparam int CP_W = 31;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ST_BAD_CONT  = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_OVERLONG  = 3'd4;
  localparam logic [2:0] ST_EXCLUDED  = 3'd5;

  localparam logic [CP_W-1:0] SURR_LO = 31'h0000_d800;
  localparam logic [CP_W-1:0] SURR_HI = 31'h0000_dfff;
  localparam logic [CP_W-1:0] CP_MAX  = 31'h0010_ffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic [2:0]      char_bytes;
    logic [2:0]      status;
    logic [15:0]     error_offset;
    logic            string_done;
  } out_item_t;

  // sequence state that does not depend on the offset width
  typedef struct packed {
    logic [2:0]      bytes_rem;
    logic [2:0]      char_len;
    logic [CP_W-1:0] partial;
    logic            skip;
  } dec_state_t;

endpackage

`default_nettype wire

FILE: design/utf8sd_step.sv
// ----------------------------------------------------------------------------
// utf8sd_step
// Per-byte decode logic: classifies the byte against the open sequence,
// produces the next sequence state and at most one result item.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_step #(
  parameter int CNT_W = 16
) (
  input  wire utf8sd_pkg::dec_state_t st,
  input  wire logic [CNT_W-1:0]  byte_idx,
  input  wire logic [CNT_W-1:0]  char_start,
  input  wire logic              strict_mode,
  input  wire utf8sd_pkg::in_item_t item,
  output utf8sd_pkg::dec_state_t st_nxt,
  output logic [CNT_W-1:0]       byte_idx_nxt,
  output logic [CNT_W-1:0]       char_start_nxt,
  output logic                   res_valid,
  output utf8sd_pkg::out_item_t  res
);
  import utf8sd_pkg::*;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] n;
    if (c[7] == 1'b0)                n = 3'd1;
    else if ((c & 8'he0) == 8'hc0)   n = 3'd2;
    else if ((c & 8'hf0) == 8'he0)   n = 3'd3;
    else if ((c & 8'hf8) == 8'hf0)   n = 3'd4;
    else if ((c & 8'hfc) == 8'hf8)   n = 3'd5;
    else if ((c & 8'hfe) == 8'hfc)   n = 3'd6;
    else                             n = 3'd0;
    return n;
  endfunction

  function automatic logic [CP_W-1:0] lead_bits(input logic [2:0] n, input logic [7:0] c);
    logic [CP_W-1:0] v;
    case (n)
      3'd1: v = CP_W'(c[6:0]);
      3'd2: v = CP_W'(c[4:0]);
      3'd3: v = CP_W'(c[3:0]);
      3'd4: v = CP_W'(c[2:0]);
      3'd5: v = CP_W'(c[1:0]);
      3'd6: v = CP_W'(c[0]);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CP_W-1:0] min_value(input logic [2:0] n);
    logic [CP_W-1:0] v;
    case (n)
      3'd2: v = 31'h0000_0080;
      3'd3: v = 31'h0000_0800;
      3'd4: v = 31'h0001_0000;
      3'd5: v = 31'h0020_0000;
      3'd6: v = 31'h0400_0000;
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [7:0]       b;
  logic             eos;
  logic [2:0]       len;
  logic [CNT_W-1:0] here_inc;
  logic             complete;
  logic [CP_W-1:0]  cp;

  assign b   = item.data_byte;
  assign eos = item.end_of_string;
  assign len = lead_len(b);
  assign here_inc = (byte_idx == {CNT_W{1'b1}}) ? byte_idx : byte_idx + CNT_W'(1);

  always_comb begin
    st_nxt         = st;
    char_start_nxt = char_start;
    res_valid      = 1'b0;
    res            = '0;
    res.string_done = eos;
    complete       = 1'b0;

    if (st.skip) begin
      // dropping bytes after an error
    end else if (st.bytes_rem == 3'd0) begin
      if (len == 3'd0) begin
        res_valid        = 1'b1;
        res.status       = ST_BAD_LEAD;
        res.error_offset = 16'(byte_idx);
        st_nxt.skip      = 1'b1;
      end else begin
        st_nxt.char_len  = len;
        char_start_nxt   = byte_idx;
        st_nxt.partial   = lead_bits(len, b);
        st_nxt.bytes_rem = len - 3'd1;
        if (len == 3'd1) begin
          complete = 1'b1;
        end else if (eos) begin
          res_valid        = 1'b1;
          res.status       = ST_TRUNC;
          res.error_offset = 16'(here_inc);
        end
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        res_valid        = 1'b1;
        res.status       = ST_BAD_CONT;
        res.error_offset = 16'(byte_idx);
        st_nxt.skip      = 1'b1;
        st_nxt.bytes_rem = 3'd0;
      end else begin
        st_nxt.partial   = {st.partial[CP_W-7:0], b[5:0]};
        st_nxt.bytes_rem = st.bytes_rem - 3'd1;
        if (st.bytes_rem == 3'd1) begin
          complete = 1'b1;
        end else if (eos) begin
          res_valid        = 1'b1;
          res.status       = ST_TRUNC;
          res.error_offset = 16'(here_inc);
        end
      end
    end

    cp = st_nxt.partial;
    if (complete) begin
      res_valid = 1'b1;
      if (cp < min_value(st_nxt.char_len)) begin
        res.status       = ST_OVERLONG;
        res.error_offset = 16'(char_start_nxt);
        st_nxt.skip      = 1'b1;
      end else if (strict_mode && ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX)) begin
        res.status       = ST_EXCLUDED;
        res.error_offset = 16'(char_start_nxt);
        st_nxt.skip      = 1'b1;
      end else begin
        res.status     = ST_OK;
        res.codepoint  = cp;
        res.char_bytes = st_nxt.char_len;
      end
    end

    // the final byte of a string resets the sequence tracking
    if (eos) begin
      st_nxt.bytes_rem = 3'd0;
      st_nxt.skip      = 1'b0;
      byte_idx_nxt     = '0;
    end else begin
      byte_idx_nxt     = here_inc;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8_stream_decode_validate_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decode_validate_core
// UTF-8 decoder and validator, one byte per cycle unless the receiver stalls,
// for sequences of 1 to 6 bytes with per-string error reporting.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte per word with an end-of-string flag
//   out_* : zero or one result word per input byte: code point and length,
//           or an error status with the byte offset of the fault
//   cfg_* : strict_mode write (always ready), only while the block is idle
// An accepted byte is held in the input register and decoded from there;
// its result is captured in the result register when the decode stage
// advances, and out_valid is driven from that register.
// Throughput is one byte per cycle unless the receiver stalls, set by the
// single decode stage between the input register and the result register.
// When the receiver stalls with a result pending, the decode stage holds and
// in_ready drops once the input register is also full.
// Reset (rst_n low, synchronous) empties both registers, clears the sequence
// state and offset counter and sets strict_mode to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decode_validate_core #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire utf8sd_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output utf8sd_pkg::out_item_t out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_strict_mode
);
  import utf8sd_pkg::*;

  // offsets saturate at the smaller of 2^OFFSET_BITS-1 and 16'hffff
  localparam int CNT_W = (OFFSET_BITS >= 16) ? 16 : OFFSET_BITS;

  logic             strict_r;
  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  dec_state_t       st_r;
  dec_state_t       st_nxt;
  logic [CNT_W-1:0] byte_idx_r;
  logic [CNT_W-1:0] byte_idx_nxt;
  logic [CNT_W-1:0] char_start_r;
  logic [CNT_W-1:0] char_start_nxt;
  logic             res_valid;
  out_item_t        res;
  logic             s1_go;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  utf8sd_step #(
    .CNT_W(CNT_W)
  ) u_step (
    .st             (st_r),
    .byte_idx       (byte_idx_r),
    .char_start     (char_start_r),
    .strict_mode    (strict_r),
    .item           (s1_item_r),
    .st_nxt         (st_nxt),
    .byte_idx_nxt   (byte_idx_nxt),
    .char_start_nxt (char_start_nxt),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r     <= 1'b1;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '0;
      byte_idx_r   <= '0;
      char_start_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        strict_r <= cfg_strict_mode;
      end
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        st_r         <= st_nxt;
        byte_idx_r   <= byte_idx_nxt;
        char_start_r <= char_start_nxt;
        out_valid_r  <= res_valid;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (s1_go && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: bench/utf8_stream_decode_validate_core_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_decode_validate_core_tb
// Self-checking bench for the UTF-8 stream decoder. Bytes are pushed through
// the valid/ready input, and a bit-accurate decoder model inside the bench
// predicts every result word. Each result is compared field by field against
// the oldest prediction. Covered: directed corner strings and random strings
// in strict and raw mode with idle and stall bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decode_validate_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8sd_pkg::*;

  localparam int          OFFSET_BITS = 16;
  localparam logic [15:0] OFFSET_SAT  = (OFFSET_BITS >= 16) ? 16'hffff :
                                        16'((1 << OFFSET_BITS) - 1);
  localparam int          SETTLE      = 6;
  localparam int          STALL_LIMIT = 4000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_strict_mode = 1'b1;

  // decoder model state
  logic            strict_on = 1'b1;
  logic [2:0]      conts_left = '0;
  logic [2:0]      seq_len = '0;
  logic [CP_W-1:0] acc = '0;
  logic [15:0]     byte_pos = '0;
  logic [15:0]     seq_start = '0;
  logic            dropping = 1'b0;

  out_item_t   expected_chars[$];
  logic [7:0]  str_q[$];

  bit in_held = 1'b0;
  bit calm = 1'b0;
  int mismatches = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int results_seen = 0;
  int error_results = 0;
  int strict_writes = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  utf8_stream_decode_validate_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_strict_mode(cfg_strict_mode)
  );

  always #5 clk = ~clk;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    casez (b)
      8'b0???????: lead_len = 3'd1;
      8'b110?????: lead_len = 3'd2;
      8'b1110????: lead_len = 3'd3;
      8'b11110???: lead_len = 3'd4;
      8'b111110??: lead_len = 3'd5;
      8'b1111110?: lead_len = 3'd6;
      default:     lead_len = 3'd0;
    endcase
  endfunction

  // smallest value that needs a sequence of this length
  function automatic logic [CP_W-1:0] floor_of(input int n);
    case (n)
      2:       floor_of = 31'h0000_0080;
      3:       floor_of = 31'h0000_0800;
      4:       floor_of = 31'h0001_0000;
      5:       floor_of = 31'h0020_0000;
      6:       floor_of = 31'h0400_0000;
      default: floor_of = '0;
    endcase
  endfunction

  function automatic logic [15:0] next_offset(input logic [15:0] v);
    next_offset = (v >= OFFSET_SAT) ? OFFSET_SAT : v + 16'd1;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("ERROR: %s", msg);
  endtask

  // advance the model by one accepted word and queue the result it causes
  task automatic decode_byte(input in_item_t it);
    out_item_t   r;
    bit          emit;
    bit          whole;
    logic [15:0] here;
    logic [2:0]  n;
    r = '0;
    emit = 1'b0;
    whole = 1'b0;
    here = byte_pos;
    if (!dropping) live_bytes++;
    if (dropping) begin
    end else if (conts_left == 0) begin
      n = lead_len(it.data_byte);
      if (n == 0) begin
        r.status = ST_BAD_LEAD;
        r.error_offset = here;
        dropping = 1'b1;
        emit = 1'b1;
      end else begin
        seq_len = n;
        seq_start = here;
        acc = CP_W'(it.data_byte & (8'hff >> ((n == 1) ? 1 : n + 1)));
        conts_left = n - 3'd1;
        if (conts_left == 0) begin
          whole = 1'b1;
        end else if (it.end_of_string) begin
          r.status = ST_TRUNC;
          r.error_offset = next_offset(here);
          emit = 1'b1;
        end
      end
    end else if (it.data_byte[7:6] != 2'b10) begin
      r.status = ST_BAD_CONT;
      r.error_offset = here;
      dropping = 1'b1;
      conts_left = '0;
      emit = 1'b1;
    end else begin
      acc = {acc[CP_W-7:0], it.data_byte[5:0]};
      conts_left = conts_left - 3'd1;
      if (conts_left == 0) begin
        whole = 1'b1;
      end else if (it.end_of_string) begin
        r.status = ST_TRUNC;
        r.error_offset = next_offset(here);
        emit = 1'b1;
      end
    end
    if (whole) begin
      emit = 1'b1;
      // overlong takes priority over the excluded ranges
      if (acc < floor_of(seq_len)) begin
        r.status = ST_OVERLONG;
        r.error_offset = seq_start;
        dropping = 1'b1;
      end else if (strict_on && ((acc >= SURR_LO && acc <= SURR_HI) || acc > CP_MAX)) begin
        r.status = ST_EXCLUDED;
        r.error_offset = seq_start;
        dropping = 1'b1;
      end else begin
        r.status = ST_OK;
        r.codepoint = acc;
        r.char_bytes = seq_len;
      end
    end
    if (emit) begin
      r.string_done = it.end_of_string;
      expected_chars.push_back(r);
    end
    if (it.end_of_string) begin
      conts_left = '0;
      byte_pos = '0;
      dropping = 1'b0;
    end else begin
      byte_pos = next_offset(byte_pos);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_item_t it;
    int       gap;
    it.data_byte = b;
    it.end_of_string = eos;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    // valid may have been lowered in this very step
    if (gap == 0 && !in_held) gap = 1;
    if (gap != 0) begin
      if (in_held) in_valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    in_held = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(it);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$], input bit close);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], close && (i == s.size() - 1));
  endtask

  task automatic wait_quiet();
    if (in_held) in_valid <= 1'b0;
    in_held = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    // dropped bytes cause no result but may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_strict(input logic v);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_strict_mode <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    strict_on = v;
    strict_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 3) pick_len = 1;
    else if (r <= 5) pick_len = 2;
    else pick_len = r - 3;
  endfunction

  function automatic logic [CP_W-1:0] pick_value(input int n);
    int unsigned vbits;
    int unsigned top;
    int unsigned lo;
    vbits = (n == 1) ? 7 : 5 * n + 1;
    top = (32'd1 << vbits) - 1;
    lo = floor_of(n);
    case ($urandom_range(0, 11))
      0:       pick_value = '0;
      1:       pick_value = CP_W'(lo);
      2:       pick_value = CP_W'(top);
      3:       pick_value = CP_W'(($urandom_range(0, 1) ? 0 : lo) + $urandom % (lo + 1));
      4:       pick_value = CP_W'((SURR_LO + $urandom_range(0, 16'h07ff)) & top);
      5:       pick_value = CP_W'((CP_MAX + $urandom_range(0, 1)) & top);
      default: pick_value = CP_W'(lo + $urandom % (top - lo + 1));
    endcase
  endfunction

  task automatic push_char(input int n, input logic [CP_W-1:0] cp);
    if (n == 1) begin
      str_q.push_back({1'b0, cp[6:0]});
    end else begin
      str_q.push_back((8'hff << (8 - n)) | (8'(cp >> (6 * (n - 1))) & (8'hff >> (n + 1))));
      for (int k = n - 2; k >= 0; k--) str_q.push_back(8'h80 | (8'(cp >> (6 * k)) & 8'h3f));
    end
  endtask

  // mostly well-formed characters, some noise and cut-off sequences
  task automatic send_random_string();
    int n;
    int cut;
    str_q.delete();
    repeat ($urandom_range(1, 8)) begin
      n = pick_len();
      case ($urandom_range(0, 11))
        9:  str_q.push_back(8'($urandom_range(0, 255)));
        10: begin
          push_char(n, pick_value(n));
          if (n > 1) begin
            cut = $urandom_range(1, n - 1);
            repeat (cut) void'(str_q.pop_back());
          end
        end
        11: str_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        default: push_char(n, pick_value(n));
      endcase
    end
    send_string(str_q, 1'b1);
  endtask

  task automatic test_directed_strict();
    logic [7:0] s[$];
    s = '{8'h00, 8'h7f, 8'hc3, 8'ha9, 8'hf4, 8'h90, 8'h80, 8'h80, 8'h41};
    send_string(s, 1'b1);
    s = '{8'he0, 8'h80, 8'h80, 8'hff};
    send_string(s, 1'b1);
    s = '{8'hc3, 8'h41};
    send_string(s, 1'b1);
    s = '{8'hfe};
    send_string(s, 1'b1);
    s = '{8'he2, 8'h82};
    send_string(s, 1'b1);
    s = '{8'h80, 8'hff};
    send_string(s, 1'b1);
    s = '{8'hed, 8'ha0, 8'h80};
    send_string(s, 1'b1);
  endtask

  task automatic test_directed_raw();
    logic [7:0] s[$];
    write_strict(1'b0);
    s = '{8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf};
    send_string(s, 1'b1);
  endtask

  task automatic test_random_phase(input int target, input logic mode, input bit pause_mid);
    int  start;
    bit  paused;
    write_strict(mode);
    start = live_bytes;
    paused = 1'b0;
    while (live_bytes - start < target) begin
      send_random_string();
      if (pause_mid && !paused && live_bytes - start >= target / 2) begin
        wait_quiet();
        paused = 1'b1;
      end
    end
  endtask

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.status != ST_OK) error_results++;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected result word status=%0d off=%0d",
                         out_data.status, out_data.error_offset));
      end else begin
        want = expected_chars.pop_front();
        bad = "";
        if (out_data.codepoint != want.codepoint) bad = {bad, " codepoint"};
        if (out_data.char_bytes != want.char_bytes) bad = {bad, " char_bytes"};
        if (out_data.status != want.status) bad = {bad, " status"};
        if (out_data.error_offset != want.error_offset) bad = {bad, " error_offset"};
        if (out_data.string_done != want.string_done) bad = {bad, " string_done"};
        if (bad != "") begin
          report($sformatf("result %0d bad%s: got %h/%0d/%0d/%0d/%0b want %h/%0d/%0d/%0d/%0b",
                           results_seen, bad, out_data.codepoint, out_data.char_bytes,
                           out_data.status, out_data.error_offset, out_data.string_done,
                           want.codepoint, want.char_bytes, want.status,
                           want.error_offset, want.string_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL utf8_stream_decode_validate_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_strict();
    test_directed_raw();
    test_random_phase(350, 1'b1, 1'b0);
    test_random_phase(350, 1'b0, 1'b0);
    test_random_phase(350, 1'b1, 1'b1);
    test_random_phase(300, 1'b0, 1'b0);
    calm = 1'b1;
    test_random_phase(300, 1'b1, 1'b0);
    wait_quiet();
    if (expected_chars.size() != 0) report("results still outstanding at end of run");
    $display("decoded %0d words (%0d outside error drops), %0d results, %0d of them errors",
             bytes_sent, live_bytes, results_seen, error_results);
    $display("strict/raw register written %0d times, %0d mismatches", strict_writes,
             mismatches);
    if (mismatches == 0) begin
      $display("PASS utf8_stream_decode_validate_core");
    end else begin
      $display("FAIL utf8_stream_decode_validate_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
